// ----- design/tx_frame_queue_marker_release_defines.svh -----
// Assertion macros used by the transmit queue top-level design file.
`ifndef TX_FRAME_QUEUE_MARKER_RELEASE_DEFINES_SVH
`define TX_FRAME_QUEUE_MARKER_RELEASE_DEFINES_SVH
`ifndef ASSERT_OFF
`define TFQM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfqm: same-cycle check failed");
`define TFQM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfqm: next-cycle check failed");
`else
`define TFQM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TFQM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/tfqm_pkg.sv -----
package tfqm_pkg;

  localparam int QUEUE_DEPTH_DEF   = 64;
  localparam int CMD_W             = 3;
  localparam int MARKER_W          = 8;
  localparam int STATUS_W          = 3;
  localparam int SLOT_W            = 6;
  localparam int IFL_W             = 6;
  localparam int APB_ADDR_W        = 4;
  localparam int APB_DATA_W        = 32;
  localparam logic [IFL_W-1:0] MAX_IN_FLIGHT_RST = IFL_W'(3 * 3 * 2);

  // register indexes (byte address is 4 * index)
  localparam logic [1:0] REG_TX_ENABLE     = 2'd0;
  localparam logic [1:0] REG_BUS_OPEN      = 2'd1;
  localparam logic [1:0] REG_MAX_IN_FLIGHT = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_COMMIT    = 3'd0,
    CMD_DISPATCH  = 3'd1,
    CMD_REL_TAIL  = 3'd2,
    CMD_REL_UNTIL = 3'd3,
    CMD_LOOKUP    = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_TX_OFF     = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_NOT_FOUND  = 3'd4,
    ST_NO_DISP    = 3'd5
  } status_t;

  typedef struct packed {
    logic              tx_enable;
    logic              bus_open;
    logic [IFL_W-1:0]  max_in_flight;
  } cfg_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_index;
    logic [MARKER_W-1:0] slot_marker;
    logic                dispatched;
    logic                forced_release;
    logic                raise_fifo_full;
    logic                raise_overrun;
  } res_t;

endpackage

// ----- design/tfqm_marker_ram.sv -----
module tfqm_marker_ram #(
  parameter int DEPTH = tfqm_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = tfqm_pkg::MARKER_W
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/tfqm_cfg.sv -----
module tfqm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tfqm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tfqm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tfqm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output tfqm_pkg::cfg_t                   cfg
);

  localparam int IFL_W = tfqm_pkg::IFL_W;
  localparam int DW    = tfqm_pkg::APB_DATA_W;

  tfqm_pkg::cfg_t cfg_r;
  tfqm_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        tfqm_pkg::REG_TX_ENABLE:     cfg_nxt.tx_enable     = pwdata[0];
        tfqm_pkg::REG_BUS_OPEN:      cfg_nxt.bus_open      = pwdata[0];
        tfqm_pkg::REG_MAX_IN_FLIGHT: cfg_nxt.max_in_flight = pwdata[IFL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tx_enable     <= 1'b1;
      cfg_r.bus_open      <= 1'b0;
      cfg_r.max_in_flight <= tfqm_pkg::MAX_IN_FLIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      tfqm_pkg::REG_TX_ENABLE:     prdata = DW'(cfg_r.tx_enable);
      tfqm_pkg::REG_BUS_OPEN:      prdata = DW'(cfg_r.bus_open);
      tfqm_pkg::REG_MAX_IN_FLIGHT: prdata = DW'(cfg_r.max_in_flight);
      default:                     prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ----- design/tfqm_seq.sv -----
module tfqm_seq #(
  parameter int QUEUE_DEPTH = tfqm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tfqm_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tfqm_pkg::CMD_W-1:0]     in_command,
  input  logic [tfqm_pkg::MARKER_W-1:0]  in_frame_marker,
  input  logic                           in_hw_fifo_has_room,
  input  logic                           in_hw_accept_ok,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tfqm_pkg::res_t                 out_res
);

  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int SLOT_W   = tfqm_pkg::SLOT_W;
  localparam int MARKER_W = tfqm_pkg::MARKER_W;
  localparam int IFL_W    = tfqm_pkg::IFL_W;
  localparam int CMP_W    = (PTR_W > IFL_W) ? PTR_W : IFL_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X   = (PTR_W + 1)'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RDWAIT = 4'b0010,
    S_SCAN   = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      send_r, send_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic                  full_r, full_nxt;
  logic [PTR_W-1:0]      scan_r, scan_nxt;
  tfqm_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [MARKER_W-1:0]   marker_r, marker_nxt;
  tfqm_pkg::res_t        res_r, res_nxt;
  logic                  out_valid_r, out_valid_nxt;
  tfqm_pkg::res_t        out_res_r;

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [MARKER_W-1:0]   ram_wdata;
  logic                  ram_re;
  logic [PTR_W-1:0]      ram_raddr;
  logic [MARKER_W-1:0]   ram_rdata;

  logic                  accept;
  logic                  load_out;
  logic                  empty;
  logic [PTR_W-1:0]      head_inc, send_inc, tail_inc, scan_inc;
  logic [PTR_W:0]        ifl_diff;
  logic [PTR_W-1:0]      in_flight;
  tfqm_pkg::cmd_t        in_cmd;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  tfqm_marker_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (PTR_W),
    .DW    (MARKER_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign in_cmd   = tfqm_pkg::cmd_t'(in_command);

  assign empty    = (head_r == tail_r) && !full_r;
  assign head_inc = ptr_inc(head_r);
  assign send_inc = ptr_inc(send_r);
  assign tail_inc = ptr_inc(tail_r);
  assign scan_inc = ptr_inc(scan_r);

  // frames in flight once send has advanced, modulo the ring size
  assign ifl_diff  = {1'b0, send_inc} - {1'b0, tail_r};
  assign in_flight = ifl_diff[PTR_W] ? PTR_W'(ifl_diff + DEPTH_X) : ifl_diff[PTR_W-1:0];

  assign ram_waddr = head_r;
  assign ram_wdata = in_frame_marker;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    send_nxt   = send_r;
    tail_nxt   = tail_r;
    full_nxt   = full_r;
    scan_nxt   = scan_r;
    cmd_nxt    = cmd_r;
    marker_nxt = marker_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = scan_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd;
          marker_nxt = in_frame_marker;
          res_nxt    = '0;
          state_nxt  = S_OUT;
          case (in_cmd)
            tfqm_pkg::CMD_COMMIT: begin
              if (!cfg.tx_enable) begin
                res_nxt.status = tfqm_pkg::ST_TX_OFF;
              end else if (full_r) begin
                res_nxt.status          = tfqm_pkg::ST_FULL;
                res_nxt.raise_fifo_full = 1'b1;
              end else begin
                ram_we              = 1'b1;
                res_nxt.slot_index  = SLOT_W'(head_r);
                res_nxt.slot_marker = in_frame_marker;
                head_nxt            = head_inc;
                full_nxt            = (head_inc == tail_r);
              end
            end
            tfqm_pkg::CMD_DISPATCH: begin
              if (!cfg.bus_open || send_r == head_r || !in_hw_fifo_has_room) begin
                res_nxt.status = tfqm_pkg::ST_NO_DISP;
              end else begin
                ram_re                = 1'b1;
                ram_raddr             = send_r;
                res_nxt.slot_index    = SLOT_W'(send_r);
                res_nxt.dispatched    = 1'b1;
                res_nxt.raise_overrun = !in_hw_accept_ok;
                send_nxt              = send_inc;
                if (CMP_W'(in_flight) > CMP_W'(cfg.max_in_flight) && !empty) begin
                  tail_nxt               = tail_inc;
                  full_nxt               = 1'b0;
                  res_nxt.forced_release = 1'b1;
                end
                state_nxt = S_RDWAIT;
              end
            end
            tfqm_pkg::CMD_REL_TAIL: begin
              if (empty) begin
                res_nxt.status = tfqm_pkg::ST_EMPTY;
              end else begin
                ram_re             = 1'b1;
                ram_raddr          = tail_r;
                res_nxt.slot_index = SLOT_W'(tail_r);
                tail_nxt           = tail_inc;
                full_nxt           = 1'b0;
                state_nxt          = S_RDWAIT;
              end
            end
            tfqm_pkg::CMD_REL_UNTIL, tfqm_pkg::CMD_LOOKUP: begin
              if (empty) begin
                res_nxt.status        = tfqm_pkg::ST_EMPTY;
                res_nxt.raise_overrun = 1'b1;
              end else if (tail_r == send_r) begin
                res_nxt.status = tfqm_pkg::ST_NOT_FOUND;
              end else begin
                // start the walk at tail; one slot per cycle
                ram_re    = 1'b1;
                ram_raddr = tail_r;
                scan_nxt  = tail_r;
                state_nxt = S_SCAN;
              end
            end
            tfqm_pkg::CMD_CLEAR: begin
              tail_nxt = head_r;
              send_nxt = head_r;
              full_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_RDWAIT: begin
        res_nxt.slot_marker = ram_rdata;
        state_nxt           = S_OUT;
      end
      S_SCAN: begin
        // ram_rdata holds the marker of slot scan_r
        if (ram_rdata == marker_r) begin
          res_nxt.slot_index  = SLOT_W'(scan_r);
          res_nxt.slot_marker = marker_r;
          if (cmd_r == tfqm_pkg::CMD_REL_UNTIL) begin
            tail_nxt = scan_inc;
            full_nxt = 1'b0;
          end
          state_nxt = S_OUT;
        end else if (scan_inc == send_r) begin
          res_nxt.status = tfqm_pkg::ST_NOT_FOUND;
          state_nxt      = S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = scan_inc;
          scan_nxt  = scan_inc;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      send_r      <= '0;
      tail_r      <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      send_r      <= send_nxt;
      tail_r      <= tail_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    cmd_r    <= cmd_nxt;
    marker_r <= marker_nxt;
    res_r    <= res_nxt;
    if (load_out) begin
      out_res_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- design/tx_frame_queue_marker_release.sv -----
// Transmit frame ring queue keeping one 8-bit marker per slot in a single-port-write,
// registered-read marker memory; head, send and tail pointers plus a full flag sit in
// flip-flops, and each command item returns exactly one result item with the slot index
// so frame contents can live elsewhere. Items are taken one at a time: commit, clear,
// refused and unknown commands go straight to the result state, dispatch and
// release-tail first do one memory read, and release-until-marker and lookup walk
// the slots from tail toward send (at most QUEUE_DEPTH), one memory read per slot.
// A result waits in the result state while the output register is stalled.
// A new item is taken as soon as the previous result has moved into the output register,
// even if that result is still stalled.
// Marker memory is not cleared at reset. Configuration: tx_enable at 0x0,
// bus_open at 0x4, max_in_flight at 0x8.
`include "tx_frame_queue_marker_release_defines.svh"

module tx_frame_queue_marker_release #(
  parameter int QUEUE_DEPTH = tfqm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tfqm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tfqm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tfqm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tfqm_pkg::CMD_W-1:0]       in_command,
  input  logic [tfqm_pkg::MARKER_W-1:0]    in_frame_marker,
  input  logic                             in_hw_fifo_has_room,
  input  logic                             in_hw_accept_ok,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tfqm_pkg::STATUS_W-1:0]    out_status,
  output logic [tfqm_pkg::SLOT_W-1:0]      out_slot_index,
  output logic [tfqm_pkg::MARKER_W-1:0]    out_slot_marker,
  output logic                             out_dispatched,
  output logic                             out_forced_release,
  output logic                             out_raise_fifo_full,
  output logic                             out_raise_overrun
);

  tfqm_pkg::cfg_t cfg;
  tfqm_pkg::res_t out_res;

  tfqm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfqm_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_frame_marker     (in_frame_marker),
    .in_hw_fifo_has_room (in_hw_fifo_has_room),
    .in_hw_accept_ok     (in_hw_accept_ok),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_res             (out_res)
  );

  assign out_status          = out_res.status;
  assign out_slot_index      = out_res.slot_index;
  assign out_slot_marker     = out_res.slot_marker;
  assign out_dispatched      = out_res.dispatched;
  assign out_forced_release  = out_res.forced_release;
  assign out_raise_fifo_full = out_res.raise_fifo_full;
  assign out_raise_overrun   = out_res.raise_overrun;

  `TFQM_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)
  `TFQM_ASSERT_IMP(a_no_slot_on_error, clk, rst_n,
                   out_valid && (out_status != tfqm_pkg::ST_OK),
                   (out_slot_index == '0) && (out_slot_marker == '0))
  `TFQM_ASSERT_IMP(a_forced_needs_dispatch, clk, rst_n,
                   out_valid && out_forced_release,
                   out_dispatched && (out_status == tfqm_pkg::ST_OK))
  `TFQM_ASSERT_IMP(a_fifo_full_status, clk, rst_n,
                   out_valid && out_raise_fifo_full,
                   out_status == tfqm_pkg::ST_FULL)

endmodule
